// File: hw/rtl/plrc_pkg.sv
// ----------------------------------------------------------------------------
// plrc_pkg
// Shared types and constants for the priority LRU request cache.
// ----------------------------------------------------------------------------
package plrc_pkg;

  localparam int CAPACITY_DEF = 12;

  localparam int FILE_W  = 31;
  localparam int REQ_W   = 31;
  localparam int STAMP_W = 32;
  localparam int KEY_W   = 1 + STAMP_W;   // {priority, stamp}

  // result queue
  localparam int RQ_DEPTH = 4;
  localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
  localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

  localparam logic KIND_FETCH = 1'b0;
  localparam logic KIND_RECV  = 1'b1;

  typedef enum logic [1:0] {
    ACT_AVAIL  = 2'd0,
    ACT_UPDATE = 2'd1,
    ACT_ISSUE  = 2'd2,
    ACT_CANCEL = 2'd3
  } action_t;

  typedef struct packed {
    logic               kind;
    logic [FILE_W-1:0]  file_id;
    logic               high_priority;
    logic [REQ_W-1:0]   new_request_id;
    logic               image_ok;
  } req_t;

  typedef struct packed {
    action_t            action;
    logic [FILE_W-1:0]  file_id_out;
    logic [REQ_W-1:0]   request_id_out;
    logic               priority_out;
    logic               image_valid;
    logic               last;
  } res_t;

endpackage

// File: hw/rtl/priority_lru_request_cache.sv
// ----------------------------------------------------------------------------
// priority_lru_request_cache
// Fully associative table of outstanding file requests, evicting by
// lowest (priority, recency stamp) when a miss overflows the table.
// ----------------------------------------------------------------------------
//  channel   ports                 tuser          tdata (low bit up)
//  request   in_t*    (slave)      kind           file_id, high_priority,
//                                                 new_request_id, image_ok
//  result    out_t*   (master)     action         file_id_out, request_id_out,
//                                                 priority_out, image_valid
//
//  One request per cycle: input register, then lookup, victim tree and
//  table update in the same cycle, results into a four-entry result queue.
//  Results are written into the result queue and presented from its head.
//  A request is processed only with two free queue slots, so a stalled
//  result side holds back the input register after a few requests.
//  Reset clears the valid flags and stamp counter at once; no clearing pass.
// ----------------------------------------------------------------------------
module priority_lru_request_cache
  import plrc_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // file_id, high_priority, new_request_id, image_ok
  input  logic        in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // file_id_out, request_id_out, priority_out, image_valid
  output logic [1:0]  out_tuser,  // action
  output logic        out_tlast
);

  logic in_valid_r, in_valid_nxt;
  req_t in_req_r;
  req_t in_req;
  logic fire, room2, two;
  res_t res0, res1, head;

  always_comb begin
    in_req.kind           = in_tuser;
    in_req.file_id        = in_tdata[30:0];
    in_req.high_priority  = in_tdata[31];
    in_req.new_request_id = in_tdata[62:32];
    in_req.image_ok       = in_tdata[63];
  end

  assign fire      = in_valid_r & room2;
  assign in_tready = ~in_valid_r | fire;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_tvalid && in_tready) begin
      in_valid_nxt = 1'b1;
    end else if (fire) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_req_r <= in_req;
    end
  end

  plrc_table #(.CAPACITY(CAPACITY)) u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .req   (in_req_r),
    .res0  (res0),
    .res1  (res1),
    .two   (two)
  );

  plrc_res_fifo u_res_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (fire),
    .push_two   (two),
    .din0       (res0),
    .din1       (res1),
    .room2      (room2),
    .dout_valid (out_tvalid),
    .dout_ready (out_tready),
    .dout       (head)
  );

  assign out_tdata = {head.image_valid, head.priority_out,
                      head.request_id_out, head.file_id_out};
  assign out_tuser = head.action;
  assign out_tlast = head.last;

endmodule

// File: hw/rtl/plrc_victim.sv
// ----------------------------------------------------------------------------
// plrc_victim
// Minimum-select tree over the {priority, stamp} keys; ties go to lower slot.
// ----------------------------------------------------------------------------
module plrc_victim
  import plrc_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic [KEY_W-1:0]              key_i [CAPACITY],
  output logic [$clog2(CAPACITY)-1:0]   vic_idx
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int LVL   = IDX_W;
  localparam int NP    = 1 << IDX_W;

  logic [KEY_W-1:0] key_l [LVL+1][NP];
  logic [IDX_W-1:0] idx_l [LVL+1][NP];
  logic             vld_l [LVL+1][NP];

  always_comb begin
    for (int l = 0; l <= LVL; l++) begin
      for (int n = 0; n < NP; n++) begin
        key_l[l][n] = '0;
        idx_l[l][n] = '0;
        vld_l[l][n] = 1'b0;
      end
    end
    for (int n = 0; n < CAPACITY; n++) begin
      key_l[0][n] = key_i[n];
      idx_l[0][n] = IDX_W'(n);
      vld_l[0][n] = 1'b1;
    end
    for (int l = 0; l < LVL; l++) begin
      for (int n = 0; n < (NP >> (l + 1)); n++) begin
        // right side only wins when strictly smaller
        if (vld_l[l][2*n+1] &&
            (!vld_l[l][2*n] || (key_l[l][2*n+1] < key_l[l][2*n]))) begin
          key_l[l+1][n] = key_l[l][2*n+1];
          idx_l[l+1][n] = idx_l[l][2*n+1];
        end else begin
          key_l[l+1][n] = key_l[l][2*n];
          idx_l[l+1][n] = idx_l[l][2*n];
        end
        vld_l[l+1][n] = vld_l[l][2*n] | vld_l[l][2*n+1];
      end
    end
  end

  assign vic_idx = idx_l[LVL][0];

endmodule

// File: hw/rtl/plrc_table.sv
// ----------------------------------------------------------------------------
// plrc_table
// Entry store, tag lookup and per-request decision; updates on fire.
// ----------------------------------------------------------------------------
module plrc_table
  import plrc_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic fire,
  input  req_t req,
  output res_t res0,
  output res_t res1,
  output logic two
);

  localparam int IDX_W = $clog2(CAPACITY);

  logic               valid_r [CAPACITY];
  logic [FILE_W-1:0]  file_r  [CAPACITY];
  logic [REQ_W-1:0]   reqid_r [CAPACITY];
  logic [STAMP_W-1:0] stamp_r [CAPACITY];
  logic               prio_r  [CAPACITY];
  logic               img_r   [CAPACITY];
  logic [STAMP_W-1:0] stamp_cnt_r, stamp_cnt_nxt;

  logic [KEY_W-1:0]   key     [CAPACITY];
  logic               hit, full;
  logic [IDX_W-1:0]   hit_idx, free_idx, vic_idx, ins_idx;
  logic               new_less;
  logic               ins_en, upd_en, img_en;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      key[i] = {prio_r[i], stamp_r[i]};
    end
  end

  plrc_victim #(.CAPACITY(CAPACITY)) u_victim (
    .key_i   (key),
    .vic_idx (vic_idx)
  );

  // lowest matching slot and lowest free slot
  always_comb begin
    hit      = 1'b0;
    full     = 1'b1;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (valid_r[i] && (file_r[i] == req.file_id)) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
      if (!valid_r[i]) begin
        full     = 1'b0;
        free_idx = IDX_W'(i);
      end
    end
  end

  assign new_less = {req.high_priority, stamp_cnt_r} < key[vic_idx];

  always_comb begin
    res0          = '0;
    res1          = '0;
    two           = 1'b0;
    ins_en        = 1'b0;
    ins_idx       = free_idx;
    upd_en        = 1'b0;
    img_en        = 1'b0;
    stamp_cnt_nxt = stamp_cnt_r;
    res0.file_id_out = req.file_id;
    res0.last        = 1'b1;
    if (req.kind == KIND_RECV) begin
      res0.action      = ACT_AVAIL;
      res0.image_valid = req.image_ok;
      img_en           = hit;
    end else begin
      stamp_cnt_nxt = stamp_cnt_r + STAMP_W'(1);
      if (hit) begin
        upd_en = 1'b1;
        if (img_r[hit_idx]) begin
          res0.action      = ACT_AVAIL;
          res0.image_valid = 1'b1;
        end else begin
          res0.action         = ACT_UPDATE;
          res0.request_id_out = reqid_r[hit_idx];
          res0.priority_out   = req.high_priority;
        end
      end else begin
        res0.action         = ACT_ISSUE;
        res0.request_id_out = req.new_request_id;
        res0.priority_out   = req.high_priority;
        if (!full) begin
          ins_en = 1'b1;
        end else begin
          two       = 1'b1;
          res0.last = 1'b0;
          res1.action = ACT_CANCEL;
          res1.last   = 1'b1;
          if (new_less) begin
            // new request is the least: cancel it, table untouched
            res1.file_id_out    = req.file_id;
            res1.request_id_out = req.new_request_id;
          end else begin
            res1.file_id_out    = file_r[vic_idx];
            res1.request_id_out = reqid_r[vic_idx];
            ins_en  = 1'b1;
            ins_idx = vic_idx;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stamp_cnt_r <= '0;
      for (int i = 0; i < CAPACITY; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else if (fire) begin
      stamp_cnt_r <= stamp_cnt_nxt;
      for (int i = 0; i < CAPACITY; i++) begin
        if (ins_en && (ins_idx == IDX_W'(i))) begin
          valid_r[i] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (ins_en && (ins_idx == IDX_W'(i))) begin
          file_r[i]  <= req.file_id;
          reqid_r[i] <= req.new_request_id;
          stamp_r[i] <= stamp_cnt_r;
          prio_r[i]  <= req.high_priority;
          img_r[i]   <= 1'b0;
        end
        if (upd_en && (hit_idx == IDX_W'(i))) begin
          stamp_r[i] <= stamp_cnt_r;
          prio_r[i]  <= req.high_priority;
        end
        if (img_en && (hit_idx == IDX_W'(i))) begin
          img_r[i] <= req.image_ok;
        end
      end
    end
  end

endmodule

// File: hw/rtl/plrc_res_fifo.sv
// ----------------------------------------------------------------------------
// plrc_res_fifo
// Result queue: takes one or two results per cycle, hands out one.
// ----------------------------------------------------------------------------
module plrc_res_fifo
  import plrc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  logic push_two,
  input  res_t din0,
  input  res_t din1,
  output logic room2,
  output logic dout_valid,
  input  logic dout_ready,
  output res_t dout
);

  res_t                mem [RQ_DEPTH];
  logic [RQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [RQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [RQ_CNT_W-1:0] count_r, count_nxt;
  logic                pop;
  logic [RQ_CNT_W-1:0] n_push;

  assign dout_valid = (count_r != '0);
  assign dout       = mem[rd_ptr_r];
  assign pop        = dout_valid & dout_ready;
  assign room2      = (count_r <= RQ_CNT_W'(RQ_DEPTH - 2));

  always_comb begin
    n_push     = push ? (push_two ? RQ_CNT_W'(2) : RQ_CNT_W'(1)) : '0;
    wr_ptr_nxt = wr_ptr_r + RQ_PTR_W'(n_push);
    rd_ptr_nxt = rd_ptr_r + RQ_PTR_W'(pop);
    count_nxt  = count_r + n_push - RQ_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= din0;
      if (push_two) begin
        mem[wr_ptr_r + RQ_PTR_W'(1)] <= din1;
      end
    end
  end

endmodule

// File: bench/tb_priority_lru_request_cache.sv
// ----------------------------------------------------------------------------
// tb_priority_lru_request_cache
// Self-checking bench for the priority LRU request cache. A scoreboard keeps
// its own copy of the twelve-slot table, predicts the issue, cancel, update
// and availability results of every accepted request and checks each result
// against the oldest prediction. Directed requests cover full-table eviction,
// including self-cancellation, and image hits and misses. Random requests
// follow, drawn mostly from a small pool of file ids so that hits and evictions
// are common. Both channels idle and stall at random outside the steady phases.
// ----------------------------------------------------------------------------
module tb_priority_lru_request_cache;
  import plrc_pkg::*;

  localparam int SLOTS     = CAPACITY_DEF;
  localparam int N_RANDOM  = 1700;
  localparam int POOL_SIZE = 24;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // file_id, high_priority, new_request_id, image_ok
  logic        in_tuser;   // kind
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // file_id_out, request_id_out, priority_out, image_valid
  logic [1:0]  out_tuser;  // action
  logic        out_tlast;

  bit steady_phase = 1'b0;   // no idling on either side while set

  priority_lru_request_cache dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #6 clk = ~clk;

  class request_table_scoreboard;
    bit              slot_vld  [SLOTS];
    bit [FILE_W-1:0] slot_file [SLOTS];
    bit [REQ_W-1:0]  slot_req  [SLOTS];
    bit [31:0]       slot_stamp[SLOTS];
    bit              slot_prio [SLOTS];
    bit              slot_img  [SLOTS];
    bit [31:0]       stamp_ctr;
    res_t            expected_q[$];
    int errors, n_fetch, n_recv, n_hit, n_issue, n_cancel, n_self_cancel;

    function void queue_expected(res_t e);
      expected_q.insert(expected_q.size(), e);
    endfunction

    function void note_request(req_t r);
      int       hit_slot, free_slot, victim;
      bit [31:0] stamp;
      res_t     e;
      hit_slot  = -1;
      free_slot = -1;
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_vld[i]) begin
          if (hit_slot < 0 && slot_file[i] == r.file_id) hit_slot = i;
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      e = '0;
      e.last = 1'b1;
      if (r.kind == KIND_RECV) begin
        n_recv++;
        if (hit_slot >= 0) slot_img[hit_slot] = r.image_ok;
        e.action      = ACT_AVAIL;
        e.file_id_out = r.file_id;
        e.image_valid = r.image_ok;
        queue_expected(e);
        return;
      end
      n_fetch++;
      stamp     = stamp_ctr;
      stamp_ctr = stamp_ctr + 32'd1;
      if (hit_slot >= 0) begin
        n_hit++;
        slot_stamp[hit_slot] = stamp;
        slot_prio[hit_slot]  = r.high_priority;
        e.file_id_out = r.file_id;
        if (slot_img[hit_slot]) begin
          e.action      = ACT_AVAIL;
          e.image_valid = 1'b1;
        end else begin
          e.action         = ACT_UPDATE;
          e.request_id_out = slot_req[hit_slot];
          e.priority_out   = r.high_priority;
        end
        queue_expected(e);
        return;
      end
      n_issue++;
      e.action         = ACT_ISSUE;
      e.file_id_out    = r.file_id;
      e.request_id_out = r.new_request_id;
      e.priority_out   = r.high_priority;
      if (free_slot >= 0) begin
        victim = free_slot;
        queue_expected(e);
      end else begin
        e.last = 1'b0;
        queue_expected(e);
        // lowest (priority, stamp), first slot wins a tie
        victim = 0;
        for (int i = 1; i < SLOTS; i++)
          if ({slot_prio[i], slot_stamp[i]} < {slot_prio[victim], slot_stamp[victim]})
            victim = i;
        n_cancel++;
        e.action       = ACT_CANCEL;
        e.priority_out = 1'b0;
        e.last         = 1'b1;
        if ({r.high_priority, stamp} < {slot_prio[victim], slot_stamp[victim]}) begin
          n_self_cancel++;
          queue_expected(e);
          return;
        end
        e.file_id_out    = slot_file[victim];
        e.request_id_out = slot_req[victim];
        queue_expected(e);
      end
      slot_vld[victim]   = 1'b1;
      slot_file[victim]  = r.file_id;
      slot_req[victim]   = r.new_request_id;
      slot_stamp[victim] = stamp;
      slot_prio[victim]  = r.high_priority;
      slot_img[victim]   = 1'b0;
    endfunction

    task report(string what);
      errors++;
      $display("MISMATCH: %s", what);
    endtask

    task check_result(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result: action %0d file %h",
                         got.action, got.file_id_out));
        return;
      end
      want = expected_q.pop_front();
      if (got.action !== want.action)
        report($sformatf("action %0d, expected %0d", got.action, want.action));
      if (got.file_id_out !== want.file_id_out)
        report($sformatf("file_id_out %h, expected %h", got.file_id_out, want.file_id_out));
      if (got.request_id_out !== want.request_id_out)
        report($sformatf("request_id_out %h, expected %h",
                         got.request_id_out, want.request_id_out));
      if (got.priority_out !== want.priority_out)
        report($sformatf("priority_out %b, expected %b", got.priority_out, want.priority_out));
      if (got.image_valid !== want.image_valid)
        report($sformatf("image_valid %b, expected %b", got.image_valid, want.image_valid));
      if (got.last !== want.last)
        report($sformatf("last %b, expected %b", got.last, want.last));
    endtask
  endclass

  request_table_scoreboard sb = new();

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic req_t mk_req(logic kind, logic [FILE_W-1:0] file, logic prio,
                                  logic [REQ_W-1:0] nreq, logic ok);
    req_t r;
    r.kind           = kind;
    r.file_id        = file;
    r.high_priority  = prio;
    r.new_request_id = nreq;
    r.image_ok       = ok;
    return r;
  endfunction

  task automatic send_request(input req_t r);
    int gap;
    gap = steady_phase ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= r.kind;
    in_tdata  <= {r.image_ok, r.new_request_id, r.high_priority, r.file_id};
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_request(r);
  endtask

  // result side: check on handshake, then choose the next ready value
  initial begin : result_sink
    int   stall;
    res_t got;
    out_tready = 1'b0;
    stall      = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got.action         = action_t'(out_tuser);
        got.file_id_out    = out_tdata[30:0];
        got.request_id_out = out_tdata[61:31];
        got.priority_out   = out_tdata[62];
        got.image_valid    = out_tdata[63];
        got.last           = out_tlast;
        sb.check_result(got);
      end
      if (stall > 0) begin
        stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        stall = steady_phase ? 0 : pick_gap();
      end
    end
  end

  initial begin : run_limit
    #(12 * 1000000);
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [FILE_W-1:0] pool[POOL_SIZE];
    logic [FILE_W-1:0] fid;
    req_t              r;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: receive on empty table, fill with high priority requests
    send_request(mk_req(KIND_RECV, 31'h7FFFFFFF, 1'b1, 31'h7FFFFFFF, 1'b1));
    send_request(mk_req(KIND_FETCH, 31'h0, 1'b1, 31'h7FFFFFFF, 1'b1));
    send_request(mk_req(KIND_FETCH, 31'h7FFFFFFF, 1'b1, 31'h0, 1'b0));
    for (int i = 1; i <= 10; i++)
      send_request(mk_req(KIND_FETCH, 31'(i), 1'b1, 31'(32'h100 + i), 1'b0));
    // table full: a low priority miss cancels itself
    send_request(mk_req(KIND_FETCH, 31'h55555555, 1'b0, 31'h2AAAAAAA, 1'b0));
    // high priority miss evicts the oldest entry
    send_request(mk_req(KIND_FETCH, 31'h2AAAAAAA, 1'b1, 31'h55555555, 1'b1));
    // image present hit, then decode failure hit, then plain hit
    send_request(mk_req(KIND_RECV, 31'h7FFFFFFF, 1'b0, 31'h0, 1'b1));
    send_request(mk_req(KIND_FETCH, 31'h7FFFFFFF, 1'b0, 31'h1234, 1'b0));
    send_request(mk_req(KIND_RECV, 31'h1, 1'b1, 31'h7FFFFFFF, 1'b0));
    send_request(mk_req(KIND_FETCH, 31'h1, 1'b1, 31'h0, 1'b1));
    send_request(mk_req(KIND_FETCH, 31'h2, 1'b0, 31'h0, 1'b0));
    // low priority entries now go first
    send_request(mk_req(KIND_FETCH, 31'h3C3C3C3C, 1'b1, 31'h7F00FF00, 1'b0));
    send_request(mk_req(KIND_FETCH, 31'h43C3C3C3, 1'b0, 31'h00FF00FF, 1'b1));
    // receive for a file that is not held
    send_request(mk_req(KIND_RECV, 31'h600D600D, 1'b1, 31'h7FFFFFFF, 1'b1));

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 300 == 0)
        for (int k = 0; k < POOL_SIZE; k++) pool[k] = FILE_W'($urandom());
      steady_phase = ((n / 200) % 4 == 3);
      fid = ($urandom_range(99) < 85) ? pool[$urandom_range(POOL_SIZE - 1)]
                                      : FILE_W'($urandom());
      r = mk_req(($urandom_range(99) < 30) ? KIND_RECV : KIND_FETCH, fid,
                 1'($urandom_range(1)), REQ_W'($urandom()), 1'($urandom_range(1)));
      send_request(r);
    end
    in_tvalid <= 1'b0;
    steady_phase = 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("Covered %0d requests: %0d fetches (%0d hits, %0d issues), %0d receives",
             sb.n_fetch + sb.n_recv, sb.n_fetch, sb.n_hit, sb.n_issue, sb.n_recv);
    $display("Evictions %0d, of which %0d cancelled the new request; %0d mismatches",
             sb.n_cancel, sb.n_self_cancel, sb.errors);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
